/* design/wow_flutter_tape_delay_assert.svh */
// Assertion macros of the tape delay top module.
`ifndef WOW_FLUTTER_TAPE_DELAY_ASSERT_SVH
`define WOW_FLUTTER_TAPE_DELAY_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define WFTD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define WFTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/wftd_pkg.sv */
// -----------------------------------------------------------------------------
// wftd_pkg
// Types, constants and the quarter-wave sine entry function of the tape delay.
// -----------------------------------------------------------------------------
package wftd_pkg;

  localparam int DELAY_FRAMES_DEF = 2048;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int SINE_DEPTH_DEF = 256;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WOW_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX = 2'd2;
  localparam int CFG_DATA_W = 19;

  localparam logic [18:0] WOW_STEP_RST = 19'd44739;
  localparam logic [16:0] DEPTH_RST = 17'd36864;
  localparam logic [16:0] MIX_RST = 17'd32768;
  localparam logic [31:0] SEED_RST = 32'd1234567;
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  typedef struct packed {
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
  } out_item_t;

  // Quarter-wave sine entry k of a table of depth 2**dbits, unsigned Q1.16. Elaboration only.
  function automatic logic [16:0] rom_entry(input longint k, input int dbits);
    longint x, x2, a, s;
    x = (k * 64'sd1686629713) >>> dbits;
    x2 = (x * x) >>> 30;
    a = 64'sd1073741824 - x2 / 110;
    a = 64'sd1073741824 - ((x2 * a) >>> 30) / 72;
    a = 64'sd1073741824 - ((x2 * a) >>> 30) / 42;
    a = 64'sd1073741824 - ((x2 * a) >>> 30) / 20;
    a = 64'sd1073741824 - ((x2 * a) >>> 30) / 6;
    s = (x * a) >>> 30;
    s = (s + 8192) >>> 14;
    if (s > 65536) s = 65536;
    if (s < 0) s = 0;
    return s[16:0];
  endfunction

endpackage

/* design/wftd_sine.sv */
// -----------------------------------------------------------------------------
// wftd_sine
// Quarter-wave sine lookup with a registered signed Q1.16 result.
// -----------------------------------------------------------------------------
module wftd_sine import wftd_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [17:0] sine_r
);
  localparam int IW = $clog2(SINE_TABLE_DEPTH);

  logic [16:0] rom [0:SINE_TABLE_DEPTH];
  logic [IW+1:0] n;
  logic [IW-1:0] i;
  logic [IW:0] idx;
  logic [16:0] mag;

  // Constant table built at elaboration.
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = rom_entry(k, IW);
  end

  // The top bits of the phase pick the quadrant and the table entry.
  assign n = phase[31 -: IW+2];
  assign i = n[IW-1:0];
  assign idx = n[IW] ? ((IW+1)'(SINE_TABLE_DEPTH) - {1'b0, i}) : {1'b0, i};
  assign mag = rom[idx];

  always_ff @(posedge clk) begin
    sine_r <= n[IW+1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end
endmodule

/* design/wftd_mac.sv */
// -----------------------------------------------------------------------------
// wftd_mac
// Shared multiplier: a signed product plus addend, shifted right, registered.
// -----------------------------------------------------------------------------
module wftd_mac import wftd_pkg::*; (
  input  logic               clk,
  input  logic signed [33:0] op_a,
  input  logic signed [33:0] op_b,
  input  logic signed [63:0] addend,
  input  logic [5:0]         shift,
  output logic signed [63:0] res_r
);
  logic signed [67:0] prod;

  // The sum is floored by an arithmetic shift.
  assign prod = op_a * op_b + 68'(addend);

  always_ff @(posedge clk) begin
    res_r <= 64'(prod >>> shift);
  end
endmodule

/* design/wow_flutter_tape_delay.sv */
// -----------------------------------------------------------------------------
// wow_flutter_tape_delay
// Stereo tape delay with wow and flutter modulated, interpolated read-back.
// -----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid / in_stall  in_data  (left_in, right_in)
// out      out_valid / out_stall out_data (left_out, right_out)
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
// A frame's result reaches the output register after the frame has passed through
// the sequencer steps, and the next frame can be accepted once it is there, set by
// the shared multiplier and the single read port of the delay memory.
// After reset a clearing pass zeroes every entry of the memory;
// no frame is accepted meanwhile.
// A result waits in the output register; the next frame may be accepted then.
// Configuration is always ready.
module wow_flutter_tape_delay import wftd_pkg::*; #(
  parameter int DELAY_FRAMES = DELAY_FRAMES_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
`include "wow_flutter_tape_delay_assert.svh"

  localparam int AW = $clog2(DELAY_FRAMES);
  localparam int PW = AW + 8;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_WORK, S_HOLD} state_t;

  state_t state_r;
  logic [5:0] step_r;
  logic [AW:0] clr_r;
  logic [18:0] wow_step_r;
  logic [16:0] depth_r, mix_r;
  logic [AW-1:0] wp_r;
  logic [31:0] wow_r, flut_r, seed_r;
  logic signed [31:0] lp_r [2];
  in_item_t x_r;
  logic signed [63:0] sw_r, y8_r, tilt_r;
  logic [PW-1:0] p_r;
  logic signed [23:0] a_r, b_r, res_r [2];
  logic ch_r;
  out_item_t out_r;
  logic out_valid_r;

  // Delay memory, one stereo frame per entry.
  logic [47:0] mem [DELAY_FRAMES];
  logic [47:0] rd_r;
  logic we;
  logic [AW-1:0] wa, ra;
  logic [47:0] wd;

  logic signed [17:0] sine_q;
  logic [31:0] sine_ph;
  logic signed [33:0] m_a, m_b;
  logic signed [63:0] m_add, m_res;
  logic [5:0] m_sh;
  logic signed [23:0] xs, rs_a, rs_b;
  logic [16:0] mix_sat;
  logic [31:0] noise_u;
  logic signed [63:0] lp_sum;

  wftd_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
    .clk(clk), .phase(sine_ph), .sine_r(sine_q));

  wftd_mac u_mac (
    .clk(clk), .op_a(m_a), .op_b(m_b), .addend(m_add), .shift(m_sh), .res_r(m_res));

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign mix_sat = mix_r[16] ? 17'd65536 : mix_r;
  assign sine_ph = (step_r == 6'd0) ? wow_r : flut_r;
  assign xs = ch_r ? x_r.right_in : x_r.left_in;
  assign rs_a = ch_r ? $signed(a_r) : $signed(a_r);
  assign rs_b = b_r;
  assign noise_u = {9'd0, seed_r[31:9]};

  // Memory port: clearing pass or sample write; the sample is written before
  // the taps are read, so a tap at the write address sees the new frame.
  always_comb begin
    we = 1'b0;
    wa = wp_r;
    wd = x_r;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
      wa = clr_r[AW-1:0];
      wd = '0;
    end else if (state_r == S_WORK && step_r == 6'd5) begin
      we = 1'b1;
    end
    ra = (step_r == 6'd7 || step_r == 6'd17) ? AW'(p_r[PW-1:8] + 1'b1) : p_r[PW-1:8];
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  // Operand selection for the shared multiplier, by sequencer step.
  always_comb begin
    m_a = '0;
    m_b = '0;
    m_add = '0;
    m_sh = '0;
    lp_sum = 64'(lp_r[ch_r]) + m_res;
    case (step_r)
      6'd2: begin
        m_a = 34'(sw_r);
        m_b = 34'sd52429;
        m_add = 64'sd4294967296;
      end
      6'd3: begin
        m_a = 34'(sine_q);
        m_b = 34'sd3277;
        m_add = m_res;
      end
      6'd4: begin
        m_a = $signed({1'b0, m_res[32:0]});
        m_b = $signed({17'd0, depth_r});
        m_sh = 6'd33;
        if (m_res[33]) m_add = 64'($signed({1'b0, depth_r})) <<< 33;
      end
      6'd9, 6'd19: begin
        m_a = 34'(rs_a);
        m_b = 34'sd256 - 34'($signed({1'b0, p_r[7:0]}));
      end
      6'd10, 6'd20: begin
        m_a = 34'(rs_b);
        m_b = 34'($signed({1'b0, p_r[7:0]}));
        m_add = m_res;
        m_sh = 6'd8;
      end
      // The interpolated sample arrives this cycle; take it straight away.
      6'd11, 6'd21: begin
        m_a = 34'((m_res <<< 8) - 64'(lp_r[ch_r]));
        m_b = 34'sd9830;
        m_sh = 6'd16;
      end
      6'd12, 6'd22: begin
        m_a = 34'($signed({1'b0, seed_r}));
        m_b = 34'($signed({1'b0, LCG_MUL}));
        m_add = 64'(LCG_ADD);
      end
      // Tilt uses the lowpass state after this frame's update.
      6'd13, 6'd23: begin
        m_a = 34'(64'(lp_r[ch_r]) - y8_r);
        m_b = 34'sd13107;
        m_sh = 6'd16;
      end
      6'd14, 6'd24: begin
        m_a = 34'($signed({1'b0, noise_u[22:0], 1'b0})) - 34'sd8388607;
        m_b = 34'sd8389;
        m_sh = 6'd14;
      end
      6'd15, 6'd25: begin
        m_a = 34'(tilt_r + m_res - (64'(xs) <<< 8));
        m_b = $signed({17'd0, mix_sat});
        m_add = 64'(xs) <<< 24;
        m_sh = 6'd24;
      end
      default: ;
    endcase
  end

  // Sequencer and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      step_r <= '0;
      wow_step_r <= WOW_STEP_RST;
      depth_r <= DEPTH_RST;
      mix_r <= MIX_RST;
      wp_r <= '0;
      wow_r <= '0;
      flut_r <= '0;
      seed_r <= SEED_RST;
      lp_r[0] <= '0;
      lp_r[1] <= '0;
      out_valid_r <= 1'b0;
      ch_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_WOW_STEP: wow_step_r <= cfg_data;
          REG_DEPTH: depth_r <= cfg_data[16:0];
          REG_MIX: mix_r <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_HOLD) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(DELAY_FRAMES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            x_r <= in_data;
            step_r <= '0;
            ch_r <= 1'b0;
            state_r <= S_WORK;
          end
        end
        S_WORK: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            6'd1: sw_r <= 64'(sine_q);
            6'd5: p_r <= PW'({wp_r, 8'd0} - m_res[PW-1:0]);
            6'd7: a_r <= rd_r[47:24];
            6'd8: b_r <= rd_r[47:24];
            6'd17: a_r <= rd_r[23:0];
            6'd18: b_r <= rd_r[23:0];
            6'd11, 6'd21: y8_r <= m_res <<< 8;
            6'd12, 6'd22: begin
              if (lp_sum > 64'sd2147483392) lp_r[ch_r] <= 32'sd2147483392;
              else if (lp_sum < -64'sd2147483648) lp_r[ch_r] <= -32'sd2147483648;
              else lp_r[ch_r] <= lp_sum[31:0];
            end
            6'd13, 6'd23: seed_r <= m_res[31:0];
            6'd14, 6'd24: tilt_r <= y8_r + m_res;
            6'd16, 6'd26: begin
              if (m_res > 64'sd8388607) res_r[ch_r] <= 24'sd8388607;
              else if (m_res < -64'sd8388608) res_r[ch_r] <= -24'sd8388608;
              else res_r[ch_r] <= m_res[23:0];
              ch_r <= 1'b1;
            end
            6'd27: state_r <= S_HOLD;
            default: ;
          endcase
        end
        S_HOLD: begin
          if (!out_valid_r || !out_stall) begin
            out_r.left_out <= res_r[0];
            out_r.right_out <= res_r[1];
            out_valid_r <= 1'b1;
            wp_r <= wp_r + 1'b1;
            wow_r <= wow_r + 32'(wow_step_r);
            flut_r <= flut_r + 32'(wow_step_r) * 32'd12;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `WFTD_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, in_stall,
    "input accepted while busy")
  `WFTD_ASSERT_NEXT(a_result_valid, clk, rst_n, state_r == S_HOLD && !out_stall,
    out_valid, "result not presented")
  `WFTD_ASSERT_IMPL(a_no_clear_out, clk, rst_n, state_r == S_CLEAR, !out_valid,
    "result during clearing pass")
endmodule
